// ===== rtl/itfs_pkg.sv =====
// Package for the integer text field scanner: word types, codes and character helpers.
package itfs_pkg;

	// Width of the consumed-character counter and its saturation point.
	localparam int CONSUMED_BITS = 16;
	localparam int CNT_W = CONSUMED_BITS;
	localparam logic [CNT_W-1:0] CNT_LIMIT = (CONSUMED_BITS >= 16) ?
		CNT_W'(65535) : {CNT_W{1'b1}};

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_SIGN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_SIZE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_RESULT = 3'd4;

	// Base codes for the base_mode register and the working base.
	localparam logic [1:0] BASE_AUTO = 2'd0;
	localparam logic [1:0] BASE_OCT  = 2'd1;
	localparam logic [1:0] BASE_DEC  = 2'd2;
	localparam logic [1:0] BASE_HEX  = 2'd3;

	// Base codes as reported in a result.
	localparam logic [1:0] USED_DEC = 2'd1;

	// Result sizes.
	localparam logic [1:0] SIZE_8  = 2'd0;
	localparam logic [1:0] SIZE_16 = 2'd1;
	localparam logic [1:0] SIZE_32 = 2'd2;
	localparam logic [1:0] SIZE_64 = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_CONVERTED = 2'd0;
	localparam logic [1:0] ST_NO_MATCH  = 2'd1;
	localparam logic [1:0] ST_END       = 2'd2;

	// Digit value that means "not a digit in any base".
	localparam logic [5:0] NOT_DIGIT = 6'd36;

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
	} in_word_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic [1:0]  unread;
		logic [1:0]  base_used;
		logic [15:0] chars_consumed;
	} out_word_t;

	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [5:0] d;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = 6'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			d = 6'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			d = 6'(c - 8'h41 + 8'd10);
		end else begin
			d = NOT_DIGIT;
		end
		return d;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic [4:0] radix_of(input logic [1:0] b);
		logic [4:0] r;
		case (b)
			BASE_OCT: r = 5'd8;
			BASE_HEX: r = 5'd16;
			default:  r = 5'd10;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/integer_text_field_scanner.sv =====
// Integer text field scanner: one character word per cycle while results drain, one result per field.
// A word sits in the input register after acceptance and is processed by the shift-add accumulate
// into the result register, whose load raises out_valid.
// A word that ends a field stalls while the result register is full and out_ready is low.
// Reset: arst_n clears the field state and both valid flags, not the word payloads, and loads the
// configuration defaults (decimal, no width limit, sign allowed, 32-bit signed result).
module integer_text_field_scanner (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  itfs_pkg::in_word_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output itfs_pkg::out_word_t                   out_data,
	input  logic                                  cfg_we,
	input  logic [itfs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [itfs_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import itfs_pkg::*;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_SIGN,
		PH_ZERO,
		PH_X,
		PH_DIGITS
	} phase_t;

	// Configuration.
	logic [1:0] base_mode_q;
	logic [7:0] max_width_q;
	logic       allow_sign_q;
	logic [1:0] result_size_q;
	logic       signed_result_q;

	// Field state.
	phase_t           phase_q, phase_n;
	logic [63:0]      mag_q, mag_n;
	logic             ovf_q, ovf_n;
	logic             neg_q, neg_n;
	logic [7:0]       taken_q, taken_n;
	logic [1:0]       abase_q, abase_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             got_q, got_n;

	// Input and result registers.
	logic      valid_s1;
	in_word_t  item_s1;
	out_word_t res_q, res_n;
	logic      out_valid_q;

	logic emit;
	logic advance;

	assign advance   = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_comb begin
		logic [7:0]  c;
		logic        e;
		logic [5:0]  d;
		logic        budget0;
		logic        budget1;
		logic        go_head;
		logic        go_digits;
		logic        fin;
		logic [1:0]  fin_status;
		logic [1:0]  fin_unread;
		logic [1:0]  ab;
		logic [4:0]  rdx;
		logic [67:0] acc;
		logic [8:0]  take_sum;
		logic [CNT_W:0] cnt_sum;
		logic [1:0]  take_n;
		logic [63:0] fmag;
		logic        fneg;
		logic [63:0] v;

		c = item_s1.ch;
		e = item_s1.at_end;
		d = digit_of(c);
		budget0 = (max_width_q == 8'd0) || (taken_q < max_width_q);
		budget1 = (max_width_q == 8'd0) || ({1'b0, taken_q} + 9'd1 < {1'b0, max_width_q});

		phase_n = phase_q;
		mag_n   = mag_q;
		ovf_n   = ovf_q;
		neg_n   = neg_q;
		abase_n = abase_q;
		got_n   = got_q;
		take_n  = 2'd0;
		ab      = abase_q;
		go_head    = 1'b0;
		go_digits  = 1'b0;
		fin        = 1'b0;
		fin_status = ST_CONVERTED;
		fin_unread = 2'd0;

		case (phase_q)
			PH_SKIP: begin
				if (!e && is_space(c)) begin
					take_n = 2'd0;
				end else begin
					ab = base_mode_q;
					if (!e && allow_sign_q && (c == 8'h2b || c == 8'h2d)) begin
						neg_n   = (c == 8'h2d);
						take_n  = 2'd1;
						phase_n = PH_SIGN;
					end else begin
						go_head = 1'b1;
					end
				end
			end
			PH_SIGN: begin
				go_head = 1'b1;
			end
			PH_ZERO: begin
				if (!e && (ab == BASE_HEX || ab == BASE_AUTO) &&
					(c == 8'h78 || c == 8'h58) && budget0) begin
					phase_n = PH_X;
				end else begin
					if (ab == BASE_AUTO) ab = BASE_OCT;
					go_digits = 1'b1;
				end
			end
			PH_X: begin
				if (!e && d < 6'd16 && budget1) begin
					// The prefix 'x' and the first hex digit are taken together.
					ab      = BASE_HEX;
					take_n  = 2'd2;
					mag_n   = {58'd0, d};
					got_n   = 1'b1;
					phase_n = PH_DIGITS;
				end else begin
					if (ab == BASE_AUTO) ab = BASE_OCT;
					fin        = 1'b1;
					fin_status = ST_CONVERTED;
					fin_unread = e ? 2'd1 : 2'd2;
				end
			end
			default: begin
				go_digits = 1'b1;
			end
		endcase

		if (go_head) begin
			if (!e && c == 8'h30 && budget0) begin
				take_n  = 2'd1;
				got_n   = 1'b1;
				phase_n = PH_ZERO;
			end else begin
				if (ab == BASE_AUTO) ab = BASE_DEC;
				go_digits = 1'b1;
			end
		end

		rdx = radix_of(ab);
		case (rdx)
			5'd8:    acc = {mag_q, 3'b000, 1'b0} >> 1;
			5'd16:   acc = {mag_q, 4'b0000};
			default: acc = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0};
		endcase
		acc = acc + {62'd0, d};

		if (go_digits) begin
			phase_n = PH_DIGITS;
			if (!e && budget0 && {1'b0, d} < {1'b0, rdx}) begin
				// A carry out of 64 bits means the value no longer fits.
				if (!ovf_q) begin
					if (|acc[67:64]) begin
						ovf_n = 1'b1;
					end else begin
						mag_n = acc[63:0];
					end
				end
				got_n  = 1'b1;
				take_n = 2'd1;
			end else begin
				fin        = 1'b1;
				fin_unread = e ? 2'd0 : 2'd1;
				if (taken_q == 8'd0) begin
					fin_status = e ? ST_END : ST_NO_MATCH;
				end else begin
					fin_status = got_q ? ST_CONVERTED : ST_NO_MATCH;
				end
			end
		end
		abase_n = ab;

		take_sum = {1'b0, taken_q} + {7'd0, take_n};
		taken_n  = (take_sum > 9'd255) ? 8'd255 : take_sum[7:0];
		cnt_sum  = {1'b0, cnt_q} + (CNT_W+1)'(take_n);
		if (phase_q == PH_SKIP && !e && is_space(c)) begin
			cnt_sum = {1'b0, cnt_q} + (CNT_W+1)'(1);
		end
		cnt_n = (cnt_sum > {1'b0, CNT_LIMIT}) ? CNT_LIMIT : cnt_sum[CNT_W-1:0];

		// Final value: saturated magnitude drops the sign, then truncate and extend.
		fmag = ovf_q ? {64{1'b1}} : mag_q;
		fneg = ovf_q ? 1'b0 : neg_q;
		v = fneg ? (64'd0 - fmag) : fmag;
		case (result_size_q)
			SIZE_8:  v = {{56{signed_result_q & v[7]}}, v[7:0]};
			SIZE_16: v = {{48{signed_result_q & v[15]}}, v[15:0]};
			SIZE_32: v = {{32{signed_result_q & v[31]}}, v[31:0]};
			default: v = v;
		endcase

		emit = valid_s1 && fin;
		res_n.value          = (fin_status == ST_CONVERTED) ? v : 64'd0;
		res_n.status         = fin_status;
		res_n.unread         = fin_unread;
		res_n.base_used      = (ab == BASE_AUTO) ? USED_DEC : ab - 2'd1;
		res_n.chars_consumed = 16'(cnt_q);

		if (fin) begin
			phase_n = PH_SKIP;
			mag_n   = 64'd0;
			ovf_n   = 1'b0;
			neg_n   = 1'b0;
			taken_n = 8'd0;
			abase_n = BASE_AUTO;
			cnt_n   = '0;
			got_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_mode_q     <= BASE_DEC;
			max_width_q     <= 8'd0;
			allow_sign_q    <= 1'b1;
			result_size_q   <= SIZE_32;
			signed_result_q <= 1'b1;
			phase_q         <= PH_SKIP;
			mag_q           <= 64'd0;
			ovf_q           <= 1'b0;
			neg_q           <= 1'b0;
			taken_q         <= 8'd0;
			abase_q         <= BASE_AUTO;
			cnt_q           <= '0;
			got_q           <= 1'b0;
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_MODE:     base_mode_q     <= cfg_data[1:0];
					REG_MAX_WIDTH:     max_width_q     <= cfg_data[7:0];
					REG_ALLOW_SIGN:    allow_sign_q    <= cfg_data[0];
					REG_RESULT_SIZE:   result_size_q   <= cfg_data[1:0];
					REG_SIGNED_RESULT: signed_result_q <= cfg_data[0];
					default:           ;
				endcase
			end
			if (advance) begin
				phase_q <= phase_n;
				mag_q   <= mag_n;
				ovf_q   <= ovf_n;
				neg_q   <= neg_n;
				taken_q <= taken_n;
				abase_q <= abase_n;
				cnt_q   <= cnt_n;
				got_q   <= got_n;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance && emit) begin
			res_q <= res_n;
		end
	end

endmodule
